// ----- hdl/m4inv_pkg.sv -----
// Package for the 4x4 matrix inverse block: widths, sequencer states and
// cofactor index helpers. No dependencies.
package m4inv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EW        = 32;                       // element width
    localparam int AW        = 100;                      // signed cofactor width
    localparam int DW        = 136;                      // signed determinant width
    localparam int NW        = AW + 2 * FRAC_BITS;       // dividend width
    localparam int RW        = DW + 1;                   // partial remainder width
    localparam int ALIMBS    = (AW + EW - 1) / EW;
    localparam int LW        = $clog2(ALIMBS);
    localparam int CW        = $clog2(NW);
    localparam int NTERMS    = 6;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_D0,
        ST_D1,
        ST_D2,
        ST_CHK,
        ST_N,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    function automatic logic [EW-1:0] mag32(input logic [EW-1:0] v);
        return v[EW-1] ? (~v + 1'b1) : v;
    endfunction

    // column slot of factor k in permutation p of a 3x3 determinant
    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
        logic [1:0] c;
        c = 2'd0;
        case (p)
            3'd0: c = k;
            3'd1: c = (k == 2'd0) ? 2'd1 : (k == 2'd1) ? 2'd2 : 2'd0;
            3'd2: c = (k == 2'd0) ? 2'd2 : (k == 2'd1) ? 2'd0 : 2'd1;
            3'd3: c = (k == 2'd0) ? 2'd0 : (k == 2'd1) ? 2'd2 : 2'd1;
            3'd4: c = (k == 2'd0) ? 2'd2 : (k == 2'd1) ? 2'd1 : 2'd0;
            3'd5: c = (k == 2'd0) ? 2'd1 : (k == 2'd1) ? 2'd0 : 2'd2;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic perm_neg(input logic [2:0] p);
        return (p == 3'd3) || (p == 3'd4) || (p == 3'd5);
    endfunction

    // flat index of factor k of term p in the minor for adjugate entry i
    function automatic logic [3:0] cof_idx(input logic [3:0] i, input logic [2:0] p,
                                           input logic [1:0] k);
        logic [1:0] dr;
        logic [1:0] dc;
        logic [1:0] slot;
        logic [1:0] row;
        logic [1:0] col;
        dr   = i[1:0];
        dc   = i[3:2];
        slot = perm_col(p, k);
        row  = (k < dr) ? k : k + 2'd1;
        col  = (slot < dc) ? slot : slot + 2'd1;
        return {row, col};
    endfunction

endpackage

// ----- hdl/matrix4_inverse_cofactor_top.sv -----
// 4x4 matrix inverse by adjugate, Q16.16 stream in and out.
// Depends on m4inv_pkg.

// Sixteen elements load one per cycle. After the last one the block is busy:
// 96 triple products, each stepped through states ST_T0 to ST_T4, through one
// shared 32x32 multiplier, then 4 x 4 limb products for the determinant, then
// per output a restoring divider that retires one quotient bit per cycle over
// the NW = 132 dividend bits, with setup and handoff states around it. Output
// waits on m_tready; a singular matrix skips the divisions.
module matrix4_inverse_cofactor_top
    import m4inv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // element_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value
    output logic [5:0]  m_tuser,   // result_index[3:0], singular, overflow
    output logic        m_tlast    // last_result
);

    state_t state_reg, state_next;

    logic [EW-1:0]        elem_mem [16];
    logic signed [AW-1:0] adj_mem [16];

    logic [3:0]  cnt_reg;
    logic [3:0]  i_reg;
    logic [2:0]  p_reg;
    logic [1:0]  j_reg;
    logic [LW-1:0] limb_reg;
    logic [CW-1:0] bit_reg;

    logic [EW-1:0]          opa_reg;
    logic                   sgn_reg;
    logic [2*EW-1:0]        prod_reg;
    logic [2*EW-1:0]        tlo_reg;
    logic [2*EW-1:0]        thi_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [ALIMBS*EW-1:0]   amag_reg;
    logic signed [DW-1:0]   det_reg;
    logic [DW-1:0]          den_reg;
    logic                   dneg_reg;
    logic                   nneg_reg;
    logic [NW-1:0]          num_reg;
    logic [DW-1:0]          rem_reg;
    logic [EW:0]            q_reg;
    logic                   big_reg;

    logic [31:0] val_reg;
    logic [3:0]  idx_reg;
    logic        sing_reg;
    logic        ovf_reg;
    logic        last_reg;

    logic [3:0]       rd_idx;
    logic [EW-1:0]    rd_val;
    logic [EW-1:0]    rd_mag;
    logic [3:0]       adj_idx;
    logic signed [AW-1:0] adj_rd;
    logic [AW-1:0]    adj_mag;
    logic [1:0]       k_sel;
    logic [EW-1:0]    mul_x;
    logic [EW-1:0]    mul_y;
    logic [2*EW-1:0]  mul_p;
    logic [AW-1:0]    term;
    logic signed [AW-1:0] acc_next;
    logic [DW-1:0]    dsh;
    logic signed [DW-1:0] det_next;
    logic [RW-1:0]    rem_sh;
    logic             q_bit;
    logic [DW-1:0]    rem_next;
    logic             in_acc;
    logic             out_acc;
    logic             fin_neg;
    logic             fin_ovf;
    logic [31:0]      fin_val;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        case (state_reg)
            ST_T0:   k_sel = 2'd0;
            ST_T1:   k_sel = 2'd1;
            default: k_sel = 2'd2;
        endcase
    end

    assign rd_idx  = (state_reg inside {ST_D0, ST_D1}) ? {2'b00, j_reg}
                                                       : cof_idx(i_reg, p_reg, k_sel);
    assign rd_val  = elem_mem[rd_idx];
    assign rd_mag  = mag32(rd_val);
    assign adj_idx = (state_reg == ST_D0) ? {j_reg, 2'b00} : i_reg;
    assign adj_rd  = adj_mem[adj_idx];
    assign adj_mag = adj_rd[AW-1] ? AW'(-adj_rd) : AW'(adj_rd);

    always_comb
    begin
        mul_x = '0;
        mul_y = rd_mag;
        case (state_reg)
            ST_T1:   mul_x = opa_reg;
            ST_T2:   mul_x = prod_reg[EW-1:0];
            ST_T3:   mul_x = prod_reg[2*EW-1:EW];
            ST_D1:   mul_x = amag_reg[limb_reg*EW +: EW];
            default: mul_x = '0;
        endcase
    end
    assign mul_p = mul_x * mul_y;

    assign term     = AW'({thi_reg, {EW{1'b0}}}) + AW'(tlo_reg);
    assign acc_next = sgn_reg ? acc_reg - $signed(term) : acc_reg + $signed(term);
    assign dsh      = DW'(prod_reg) << (limb_reg * EW);
    assign det_next = sgn_reg ? det_reg - $signed(dsh) : det_reg + $signed(dsh);

    assign rem_sh   = {rem_reg, num_reg[NW-1]};
    assign q_bit    = rem_sh >= {1'b0, den_reg};
    assign rem_next = q_bit ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);

    assign fin_neg = nneg_reg ^ dneg_reg;
    assign fin_ovf = big_reg || q_reg[EW] ||
                     (fin_neg ? (q_reg[EW-1:0] > 32'h8000_0000) : q_reg[EW-1]);
    always_comb
    begin
        if (fin_ovf)
            fin_val = fin_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            fin_val = fin_neg ? (~q_reg[EW-1:0] + 1'b1) : q_reg[EW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (in_acc && cnt_reg == 4'd15) state_next = ST_T0;
            ST_T0:   state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_T3;
            ST_T3:   state_next = ST_T4;
            ST_T4:
            begin
                if (p_reg == 3'(NTERMS - 1) && i_reg == 4'd15)
                    state_next = ST_D0;
                else
                    state_next = ST_T0;
            end
            ST_D0:   state_next = ST_D1;
            ST_D1:   state_next = ST_D2;
            ST_D2:
            begin
                if (limb_reg != LW'(ALIMBS - 1))
                    state_next = ST_D1;
                else if (j_reg == 2'd3)
                    state_next = ST_CHK;
                else
                    state_next = ST_D0;
            end
            ST_CHK:  state_next = (det_reg == '0) ? ST_OUT : ST_N;
            ST_N:    state_next = ST_DIV;
            ST_DIV:  if (bit_reg == '0) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (m_tready)
                    state_next = (sing_reg || i_reg == 4'd15) ? ST_LOAD : ST_N;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = (state_reg == ST_LOAD);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = val_reg;
        m_tuser  = {ovf_reg, sing_reg, idx_reg};
        m_tlast  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            p_reg     <= '0;
            j_reg     <= '0;
            limb_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                        i_reg   <= '0;
                        p_reg   <= '0;
                    end
                end
                ST_T4:
                begin
                    if (p_reg == 3'(NTERMS - 1))
                    begin
                        p_reg <= '0;
                        i_reg <= i_reg + 4'd1;
                        j_reg <= '0;
                    end
                    else
                        p_reg <= p_reg + 3'd1;
                end
                ST_D0:   limb_reg <= '0;
                ST_D2:
                begin
                    if (limb_reg == LW'(ALIMBS - 1))
                        j_reg <= j_reg + 2'd1;
                    else
                        limb_reg <= limb_reg + LW'(1);
                end
                ST_CHK:  i_reg <= '0;
                ST_N:    bit_reg <= CW'(NW - 1);
                ST_DIV:  bit_reg <= bit_reg - CW'(1);
                ST_OUT:  if (m_tready) i_reg <= i_reg + 4'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                    elem_mem[cnt_reg] <= s_tdata;
                acc_reg <= '0;
                det_reg <= '0;
            end
            ST_T0:
            begin
                opa_reg <= rd_mag;
                sgn_reg <= rd_val[EW-1] ^ perm_neg(p_reg) ^ i_reg[2] ^ i_reg[0];
            end
            ST_T1:
            begin
                prod_reg <= mul_p;
                sgn_reg  <= sgn_reg ^ rd_val[EW-1];
            end
            ST_T2:
            begin
                tlo_reg <= mul_p;
                sgn_reg <= sgn_reg ^ rd_val[EW-1];
            end
            ST_T3:   thi_reg <= mul_p;
            ST_T4:
            begin
                if (p_reg == 3'(NTERMS - 1))
                begin
                    adj_mem[i_reg] <= acc_next;
                    acc_reg        <= '0;
                end
                else
                    acc_reg <= acc_next;
            end
            ST_D0:
            begin
                amag_reg <= (ALIMBS * EW)'(adj_mag);
                sgn_reg  <= adj_rd[AW-1] ^ rd_val[EW-1];
            end
            ST_D1:   prod_reg <= mul_p;
            ST_D2:   det_reg  <= det_next;
            ST_CHK:
            begin
                den_reg  <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
                dneg_reg <= det_reg[DW-1];
                val_reg  <= '0;
                idx_reg  <= '0;
                sing_reg <= (det_reg == '0);
                ovf_reg  <= 1'b0;
                last_reg <= 1'b1;
            end
            ST_N:
            begin
                num_reg  <= NW'(adj_mag) << (2 * FRAC_BITS);
                nneg_reg <= adj_rd[AW-1];
                rem_reg  <= '0;
                q_reg    <= '0;
                big_reg  <= 1'b0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[EW-1:0], q_bit};
                big_reg <= big_reg | q_reg[EW];
            end
            ST_FIN:
            begin
                val_reg  <= fin_val;
                idx_reg  <= i_reg;
                sing_reg <= 1'b0;
                ovf_reg  <= fin_ovf;
                last_reg <= (i_reg == 4'd15);
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output both active");

    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> (m_tlast && m_tdata == 32'h0))
        else $error("singular result malformed");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && !m_tuser[4]) |-> (m_tuser[3:0] == 4'hF))
        else $error("last on wrong index");

    a_back_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_tlast) |=> s_tready)
        else $error("not back to loading after last result");
`endif

endmodule
